// File: hw/rtl/cstp_pkg.sv
// Shared types and constants of the cache tag and policy block.
// Request codes, the decoded queue word, configuration bundle and defaults.
// No dependencies.
`default_nettype none

package cstp_pkg;

   // default geometry; all three must be powers of two
   localparam int LINE_BYTES_DEFAULT = 32;
   localparam int SET_COUNT_DEFAULT  = 64;
   localparam int WAY_COUNT_DEFAULT  = 4;

   localparam int QUEUE_DEPTH = 2;

   // request codes on req_type
   localparam logic [3:0] REQ_READ           = 4'd0;
   localparam logic [3:0] REQ_WRITE          = 4'd1;
   localparam logic [3:0] REQ_INVAL_VA       = 4'd2;
   localparam logic [3:0] REQ_CLEAN_VA       = 4'd3;
   localparam logic [3:0] REQ_CLEAN_INVAL_VA = 4'd4;
   localparam logic [3:0] REQ_INVAL_ALL      = 4'd5;
   localparam logic [3:0] REQ_INVAL_SW       = 4'd6;
   localparam logic [3:0] REQ_CLEAN_SW       = 4'd7;
   localparam logic [3:0] REQ_CLEAN_INVAL_SW = 4'd8;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_BACK_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCK_BASE       = 2'd1;

   // classified operation; KIND_NOP covers unknown codes and set/way out of range
   typedef enum logic [3:0] {
      KIND_READ,
      KIND_WRITE,
      KIND_INVAL_VA,
      KIND_CLEAN_VA,
      KIND_CLEAN_INVAL_VA,
      KIND_INVAL_ALL,
      KIND_INVAL_SW,
      KIND_CLEAN_SW,
      KIND_CLEAN_INVAL_SW,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] address;
      logic [31:0] fill_address;
      logic [5:0]  set_index;
      logic [1:0]  way_index;
   } entry_type;

   typedef struct packed {
      logic       write_back_mode;
      logic [2:0] lock_base;
   } cfg_type;

endpackage

`default_nettype wire

// File: hw/rtl/cstp_front.sv
// Front end: decodes and classifies an accepted request into a queue word.
// Depends on cstp_pkg.
`default_nettype none

module cstp_front #(
   parameter int LINE_BYTES = cstp_pkg::LINE_BYTES_DEFAULT,
   parameter int SET_COUNT  = cstp_pkg::SET_COUNT_DEFAULT,
   parameter int WAY_COUNT  = cstp_pkg::WAY_COUNT_DEFAULT
) (
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [3:0]           req_type,
   input  wire logic [31:0]          req_address,
   input  wire logic [31:0]          req_phys_address,
   input  wire logic [5:0]           req_set_index,
   input  wire logic [1:0]           req_way_index,
   input  wire logic                 q_full,
   output logic                      q_push,
   output cstp_pkg::entry_type       q_entry
);
   import cstp_pkg::*;

   logic sw_ok;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   assign sw_ok = (32'(req_set_index) < 32'(SET_COUNT)) &&
                  (32'(req_way_index) < 32'(WAY_COUNT));

   always_comb begin
      q_entry.address      = req_address;
      // line base of the physical address, using the virtual offset
      q_entry.fill_address = req_phys_address - (req_address & 32'(LINE_BYTES - 1));
      q_entry.set_index    = req_set_index;
      q_entry.way_index    = req_way_index;
      case (req_type)
         REQ_READ:           q_entry.kind = KIND_READ;
         REQ_WRITE:          q_entry.kind = KIND_WRITE;
         REQ_INVAL_VA:       q_entry.kind = KIND_INVAL_VA;
         REQ_CLEAN_VA:       q_entry.kind = KIND_CLEAN_VA;
         REQ_CLEAN_INVAL_VA: q_entry.kind = KIND_CLEAN_INVAL_VA;
         REQ_INVAL_ALL:      q_entry.kind = KIND_INVAL_ALL;
         REQ_INVAL_SW:       q_entry.kind = sw_ok ? KIND_INVAL_SW : KIND_NOP;
         REQ_CLEAN_SW:       q_entry.kind = sw_ok ? KIND_CLEAN_SW : KIND_NOP;
         REQ_CLEAN_INVAL_SW: q_entry.kind = sw_ok ? KIND_CLEAN_INVAL_SW : KIND_NOP;
         default:            q_entry.kind = KIND_NOP;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/cstp_queue.sv
// Short FIFO of decoded words between the front end and the back end.
// Depends on cstp_pkg.
`default_nettype none

module cstp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cstp_pkg::entry_type  push_entry,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      not_empty,
   output cstp_pkg::entry_type       head
);
   import cstp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   // hold off the front while in reset
   assign full      = reset || (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/cstp_back.sv
// Back end: tag memory, valid and dirty bits, lookup, victim choice and update.
// Two-step sequencer per word; result held in an output register. Depends on cstp_pkg.
`default_nettype none

module cstp_back #(
   parameter int LINE_BYTES = cstp_pkg::LINE_BYTES_DEFAULT,
   parameter int SET_COUNT  = cstp_pkg::SET_COUNT_DEFAULT,
   parameter int WAY_COUNT  = cstp_pkg::WAY_COUNT_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cstp_pkg::cfg_type    cfg,
   input  wire logic                 q_not_empty,
   input  wire cstp_pkg::entry_type  q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_hit,
   output logic [1:0]                rsp_way,
   output logic                      rsp_writeback,
   output logic [31:0]               rsp_writeback_address,
   output logic                      rsp_fill,
   output logic [31:0]               rsp_fill_address,
   output logic                      rsp_mem_write,
   output logic                      rsp_all_locked
);
   import cstp_pkg::*;

   localparam int OFF_W    = $clog2(LINE_BYTES);
   localparam int LOG_SETS = $clog2(SET_COUNT);
   localparam int SET_W    = (LOG_SETS > 0) ? LOG_SETS : 1;
   localparam int WAY_W    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
   localparam int TAG_W    = 32 - OFF_W - LOG_SETS;
   localparam int ROW_W    = WAY_COUNT * TAG_W;

   typedef enum logic {ST_LOOK, ST_EVAL} state_type;

   state_type        state_ff;
   entry_type        cur_ff;
   logic [SET_W-1:0] cur_set_ff;
   logic [ROW_W-1:0] tag_row_ff;
   logic [ROW_W-1:0] tag_mem [SET_COUNT];
   logic [WAY_COUNT-1:0] valid_ff [SET_COUNT];
   logic [WAY_COUNT-1:0] dirty_ff [SET_COUNT];

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [1:0]           rsp_way_ff;
   logic                 rsp_writeback_ff;
   logic [31:0]          rsp_writeback_address_ff;
   logic                 rsp_fill_ff;
   logic [31:0]          rsp_fill_address_ff;
   logic                 rsp_mem_write_ff;
   logic                 rsp_all_locked_ff;

   logic [SET_W-1:0]     head_set;
   logic [TAG_W-1:0]     cur_tag;
   logic [WAY_COUNT-1:0] row_v;
   logic [WAY_COUNT-1:0] row_d;
   logic [WAY_COUNT-1:0] hit_vec;
   logic                 hit_any;
   logic [WAY_W-1:0]     hit_way;
   logic [WAY_W-1:0]     vic_way;
   logic                 vic_found;
   logic                 vic_locked;
   logic [WAY_W-1:0]     sw_way;
   logic [3:0]           lock_ext;
   logic [WAY_W-1:0]     tgt;
   logic                 do_alloc;
   logic                 do_clean;
   logic                 do_inval;
   logic                 do_dirty;
   logic                 do_clear_all;
   logic                 commit;
   logic [TAG_W-1:0]     tgt_tag;
   logic [ROW_W-1:0]     tag_row_in;
   logic                 valid_bit_in;
   logic                 dirty_bit_in;
   logic                 hit_in;
   logic [1:0]           way_in;
   logic                 writeback_in;
   logic [31:0]          writeback_address_in;
   logic                 fill_in;
   logic [31:0]          fill_address_in;
   logic                 mem_write_in;
   logic                 all_locked_in;

   function automatic logic [SET_W-1:0] set_of(input entry_type e);
      if (e.kind inside {KIND_INVAL_SW, KIND_CLEAN_SW, KIND_CLEAN_INVAL_SW}) begin
         return SET_W'(e.set_index);
      end
      return SET_W'((e.address >> OFF_W) & 32'(SET_COUNT - 1));
   endfunction

   assign head_set = set_of(q_head);
   assign cur_tag  = TAG_W'(cur_ff.address >> (OFF_W + LOG_SETS));
   assign row_v    = valid_ff[cur_set_ff];
   assign row_d    = dirty_ff[cur_set_ff];
   assign sw_way   = WAY_W'(cur_ff.way_index);
   assign lock_ext = {1'b0, cfg.lock_base};

   assign q_pop  = (state_ff == ST_LOOK) && q_not_empty;
   assign commit = (state_ff == ST_EVAL) && (!rsp_valid_ff || rsp_ready);

   // lookup and victim choice over the ways of the set
   always_comb begin
      hit_vec   = '0;
      hit_way   = '0;
      vic_way   = '0;
      vic_found = 1'b0;
      for (int w = 0; w < WAY_COUNT; w++) begin
         hit_vec[w] = row_v[w] && (tag_row_ff[w*TAG_W +: TAG_W] == cur_tag);
      end
      for (int w = WAY_COUNT - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if ((4'(w) >= lock_ext) && !row_v[w]) begin
            vic_way   = WAY_W'(w);
            vic_found = 1'b1;
         end
      end
      hit_any    = |hit_vec;
      vic_locked = 1'b0;
      if (!vic_found) begin
         if (lock_ext < 4'(WAY_COUNT)) begin
            vic_way = WAY_W'(cfg.lock_base);
         end else begin
            vic_way    = '0;
            vic_locked = 1'b1;
         end
      end
   end

   // classify the action and build the result
   always_comb begin
      tgt              = hit_way;
      do_alloc         = 1'b0;
      do_clean         = 1'b0;
      do_inval         = 1'b0;
      do_dirty         = 1'b0;
      do_clear_all     = 1'b0;
      hit_in           = 1'b0;
      way_in           = '0;
      fill_in          = 1'b0;
      mem_write_in     = 1'b0;
      all_locked_in    = 1'b0;
      case (cur_ff.kind)
         KIND_READ, KIND_WRITE: begin
            if (hit_any) begin
               hit_in = 1'b1;
               way_in = 2'(hit_way);
               if (cur_ff.kind == KIND_WRITE) begin
                  do_dirty     = cfg.write_back_mode;
                  mem_write_in = !cfg.write_back_mode;
               end
            end else if ((cur_ff.kind == KIND_WRITE) && !cfg.write_back_mode) begin
               mem_write_in = 1'b1;
            end else begin
               tgt           = vic_way;
               way_in        = 2'(vic_way);
               do_alloc      = 1'b1;
               do_clean      = 1'b1;
               fill_in       = 1'b1;
               all_locked_in = vic_locked;
            end
         end
         KIND_INVAL_VA, KIND_CLEAN_VA, KIND_CLEAN_INVAL_VA: begin
            hit_in   = hit_any;
            way_in   = hit_any ? 2'(hit_way) : 2'd0;
            do_clean = hit_any && (cur_ff.kind != KIND_INVAL_VA);
            do_inval = hit_any && (cur_ff.kind != KIND_CLEAN_VA);
         end
         KIND_INVAL_ALL: begin
            do_clear_all = 1'b1;
         end
         KIND_INVAL_SW, KIND_CLEAN_SW, KIND_CLEAN_INVAL_SW: begin
            tgt      = sw_way;
            hit_in   = row_v[sw_way];
            way_in   = 2'(sw_way);
            do_clean = (cur_ff.kind != KIND_INVAL_SW);
            do_inval = (cur_ff.kind != KIND_CLEAN_SW);
         end
         default: begin
         end
      endcase

      tgt_tag      = tag_row_ff[tgt*TAG_W +: TAG_W];
      writeback_in = do_clean && row_d[tgt];
      writeback_address_in = writeback_in ?
         ((32'(tgt_tag) << (OFF_W + LOG_SETS)) | (32'(cur_set_ff) << OFF_W)) : 32'd0;
      fill_address_in = fill_in ? cur_ff.fill_address : 32'd0;

      // new valid and dirty bits of the target line; allocation wins over clean
      valid_bit_in = row_v[tgt];
      dirty_bit_in = row_d[tgt];
      if (do_clean) begin
         dirty_bit_in = 1'b0;
      end
      if (do_dirty) begin
         dirty_bit_in = 1'b1;
      end
      if (do_alloc) begin
         valid_bit_in = 1'b1;
         dirty_bit_in = (cur_ff.kind == KIND_WRITE);
      end
      if (do_inval) begin
         valid_bit_in = 1'b0;
      end

      tag_row_in = tag_row_ff;
      tag_row_in[tgt*TAG_W +: TAG_W] = cur_tag;
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOOK;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_LOOK: begin
               if (q_not_empty) begin
                  state_ff <= ST_EVAL;
               end
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_EVAL: begin
               if (commit) begin
                  state_ff     <= ST_LOOK;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_LOOK;
            end
         endcase
      end
      if (q_pop) begin
         cur_ff     <= q_head;
         cur_set_ff <= head_set;
      end
      if (commit) begin
         rsp_hit_ff               <= hit_in;
         rsp_way_ff               <= way_in;
         rsp_writeback_ff         <= writeback_in;
         rsp_writeback_address_ff <= writeback_address_in;
         rsp_fill_ff              <= fill_in;
         rsp_fill_address_ff      <= fill_address_in;
         rsp_mem_write_ff         <= mem_write_in;
         rsp_all_locked_ff        <= all_locked_in;
      end
   end

   // line state: valid and dirty bits reset at once, tag memory never cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SET_COUNT; s++) begin
            valid_ff[s] <= '0;
            dirty_ff[s] <= '0;
         end
      end else if (commit) begin
         if (do_clear_all) begin
            for (int s = 0; s < SET_COUNT; s++) begin
               valid_ff[s] <= '0;
               dirty_ff[s] <= '0;
            end
         end else begin
            valid_ff[cur_set_ff][tgt] <= valid_bit_in;
            dirty_ff[cur_set_ff][tgt] <= dirty_bit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         tag_row_ff <= tag_mem[head_set];
      end
      if (commit && do_alloc) begin
         tag_mem[cur_set_ff] <= tag_row_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_way               = rsp_way_ff;
   assign rsp_writeback         = rsp_writeback_ff;
   assign rsp_writeback_address = rsp_writeback_address_ff;
   assign rsp_fill              = rsp_fill_ff;
   assign rsp_fill_address      = rsp_fill_address_ff;
   assign rsp_mem_write         = rsp_mem_write_ff;
   assign rsp_all_locked        = rsp_all_locked_ff;

endmodule

`default_nettype wire

// File: hw/rtl/set_assoc_cache_tag_policy_top.sv
// Tag, valid and dirty store of a set-associative write-back data cache.
// Request channel req_*: one cache access or maintenance operation per word.
// Response channel rsp_*: one result word per request, in request order, naming
// hit and way, a dirty line to write back, a line to fill and a memory write.
// Configuration channel csr_*: write_back_mode (index 0) and lock_base (index 1),
// ready whenever out of reset; write only while no request is outstanding.
// A request passes through the queue, the back end's current-word register and its
// output register; the back end takes one request at a time: its tag memory read
// followed by the read-modify-write of tag, valid and dirty bits.
// A 2-word queue lets the front accept while the back end works; a stalled
// response holds in the output register and stalls the back end, then the queue,
// then req_ready.
// Reset holds req_ready and csr_ready low, clears valid and dirty bits at once and
// sets write-back mode, lock base 0; the tag memory is not cleared.
// LINE_BYTES, SET_COUNT, WAY_COUNT: powers of two.
// Depends on cstp_pkg, cstp_front, cstp_queue, cstp_back.
`default_nettype none

module set_assoc_cache_tag_policy_top #(
   parameter int LINE_BYTES = cstp_pkg::LINE_BYTES_DEFAULT,
   parameter int SET_COUNT  = cstp_pkg::SET_COUNT_DEFAULT,
   parameter int WAY_COUNT  = cstp_pkg::WAY_COUNT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [3:0]                      req_type,
   input  wire logic [31:0]                     req_address,
   input  wire logic [31:0]                     req_phys_address,
   input  wire logic [5:0]                      req_set_index,
   input  wire logic [1:0]                      req_way_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_hit,
   output logic [1:0]                           rsp_way,
   output logic                                 rsp_writeback,
   output logic [31:0]                          rsp_writeback_address,
   output logic                                 rsp_fill,
   output logic [31:0]                          rsp_fill_address,
   output logic                                 rsp_mem_write,
   output logic                                 rsp_all_locked,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [cstp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [cstp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cstp_pkg::*;

   cfg_type   cfg_ff;
   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_not_empty;
   entry_type q_entry;
   entry_type q_head;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.write_back_mode <= 1'b1;
         cfg_ff.lock_base       <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WRITE_BACK_MODE: cfg_ff.write_back_mode <= csr_data[0];
            CSR_LOCK_BASE:       cfg_ff.lock_base       <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   cstp_front #(
      .LINE_BYTES (LINE_BYTES),
      .SET_COUNT  (SET_COUNT),
      .WAY_COUNT  (WAY_COUNT)
   ) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_address      (req_address),
      .req_phys_address (req_phys_address),
      .req_set_index    (req_set_index),
      .req_way_index    (req_way_index),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   cstp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   cstp_back #(
      .LINE_BYTES (LINE_BYTES),
      .SET_COUNT  (SET_COUNT),
      .WAY_COUNT  (WAY_COUNT)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .q_not_empty           (q_not_empty),
      .q_head                (q_head),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_hit               (rsp_hit),
      .rsp_way               (rsp_way),
      .rsp_writeback         (rsp_writeback),
      .rsp_writeback_address (rsp_writeback_address),
      .rsp_fill              (rsp_fill),
      .rsp_fill_address      (rsp_fill_address),
      .rsp_mem_write         (rsp_mem_write),
      .rsp_all_locked        (rsp_all_locked)
   );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench of set_assoc_cache_tag_policy_top: tag, valid and dirty
// prediction in a scoreboard class, valid/ready drivers, random stall phases.
// Depends on cstp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;
   import cstp_pkg::*;

   localparam int LINE_SIZE = LINE_BYTES_DEFAULT;
   localparam int SETS      = SET_COUNT_DEFAULT;
   localparam int WAYS      = WAY_COUNT_DEFAULT;
   localparam int LINES     = SETS * WAYS;
   localparam int TAG_W     = 32 - $clog2(LINE_SIZE * SETS);

   typedef struct packed {
      logic        hit;
      logic [1:0]  way;
      logic        writeback;
      logic [31:0] writeback_address;
      logic        fill;
      logic [31:0] fill_address;
      logic        mem_write;
      logic        all_locked;
   } cache_result_type;

   class cache_tag_scoreboard;
      logic [TAG_W-1:0] line_tag [LINES];
      bit               line_valid [LINES];
      bit               line_dirty [LINES];
      bit               write_back_mode;
      logic [2:0]       lock_base;
      cache_result_type expected_q [$];
      int               error_count;

      function new();
         foreach (line_valid[i]) begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_tag[i]   = '0;
         end
         write_back_mode = 1'b1;
         lock_base       = 3'd0;
         error_count     = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_WRITE_BACK_MODE: write_back_mode = data[0];
            CSR_LOCK_BASE:       lock_base = data[2:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // flush a dirty line to memory and mark it clean
      function void clean_line(int line, logic [31:0] set, inout cache_result_type res);
         logic [31:0] base;
         if (line_dirty[line]) begin
            base = line_tag[line];
            res.writeback = 1'b1;
            res.writeback_address = (base * SETS + set) * LINE_SIZE;
         end
         line_dirty[line] = 1'b0;
      endfunction

      function void note_request(logic [3:0] op, logic [31:0] addr, logic [31:0] phys,
                                 logic [5:0] set_index, logic [1:0] way_index);
         cache_result_type res;
         logic [31:0] offset, set, tag;
         int line, victim, w, base;
         bit found, free;
         res    = '0;
         found  = 1'b0;
         line   = 0;
         offset = addr % LINE_SIZE;
         set    = (addr / LINE_SIZE) % SETS;
         tag    = addr / (LINE_SIZE * SETS);
         if (op <= REQ_CLEAN_INVAL_VA) begin
            for (w = 0; w < WAYS && !found; w++) begin
               if (line_valid[set * WAYS + w] && line_tag[set * WAYS + w] == tag) begin
                  found   = 1'b1;
                  line    = set * WAYS + w;
                  res.hit = 1'b1;
                  res.way = w[1:0];
               end
            end
         end
         case (op)
            REQ_READ, REQ_WRITE: begin
               if (found) begin
                  if (op == REQ_WRITE) begin
                     if (write_back_mode) line_dirty[line] = 1'b1;
                     else res.mem_write = 1'b1;
                  end
               end else if (op == REQ_WRITE && !write_back_mode) begin
                  res.mem_write = 1'b1;
               end else begin
                  // lowest free way at or above the lock base, else the base way itself
                  base = lock_base;
                  if (base >= WAYS) begin
                     victim = 0;
                     res.all_locked = 1'b1;
                  end else begin
                     victim = base;
                     free   = 1'b0;
                     for (w = base; w < WAYS; w++) begin
                        if (!free && !line_valid[set * WAYS + w]) begin
                           victim = w;
                           free   = 1'b1;
                        end
                     end
                  end
                  line = set * WAYS + victim;
                  res.way = victim[1:0];
                  clean_line(line, set, res);
                  res.fill = 1'b1;
                  res.fill_address = phys - offset;
                  line_tag[line]   = tag[TAG_W-1:0];
                  line_valid[line] = 1'b1;
                  line_dirty[line] = (op == REQ_WRITE);
               end
            end
            REQ_INVAL_VA: begin
               // dirty bit survives on purpose
               if (found) line_valid[line] = 1'b0;
            end
            REQ_CLEAN_VA: begin
               if (found) clean_line(line, set, res);
            end
            REQ_CLEAN_INVAL_VA: begin
               if (found) begin
                  clean_line(line, set, res);
                  line_valid[line] = 1'b0;
               end
            end
            REQ_INVAL_ALL: begin
               foreach (line_valid[i]) begin
                  line_valid[i] = 1'b0;
                  line_dirty[i] = 1'b0;
               end
            end
            REQ_INVAL_SW, REQ_CLEAN_SW, REQ_CLEAN_INVAL_SW: begin
               if (set_index < SETS && way_index < WAYS) begin
                  line    = set_index * WAYS + way_index;
                  res.hit = line_valid[line];
                  res.way = way_index;
                  if (op != REQ_INVAL_SW) clean_line(line, set_index, res);
                  if (op != REQ_CLEAN_SW) line_valid[line] = 1'b0;
               end
            end
            default: ;
         endcase
         expected_q.push_back(res);
      endfunction

      function void compare_field(string name, logic [31:0] exp_value,
                                  logic [31:0] got_value);
         if (exp_value !== got_value) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_value, got_value);
            error_count++;
         end
      endfunction

      function void check_response(cache_result_type got);
         cache_result_type exp_res;
         if (expected_q.size() == 0) begin
            $error("response word with no request outstanding");
            error_count++;
            return;
         end
         exp_res = expected_q.pop_front();
         compare_field("hit", exp_res.hit, got.hit);
         compare_field("way", exp_res.way, got.way);
         compare_field("writeback", exp_res.writeback, got.writeback);
         compare_field("writeback_address", exp_res.writeback_address,
                       got.writeback_address);
         compare_field("fill", exp_res.fill, got.fill);
         compare_field("fill_address", exp_res.fill_address, got.fill_address);
         compare_field("mem_write", exp_res.mem_write, got.mem_write);
         compare_field("all_locked", exp_res.all_locked, got.all_locked);
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 48;
   localparam bit PHASE_MODE [PHASES] = '{1, 0, 1, 0, 1, 1, 0, 1};
   localparam logic [2:0] PHASE_LOCK [PHASES] = '{0, 0, 7, 3, 4, 1, 7, 2};
   localparam logic [31:0] TAG_POOL [6] = '{0, 1, 2, 32'h1FFFFF, 32'h0AAAAA, 32'h155555};
   localparam logic [31:0] SET_POOL [4] = '{0, 63, 21, 42};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [3:0]             req_type = '0;
   logic [31:0]            req_address = '0;
   logic [31:0]            req_phys_address = '0;
   logic [5:0]             req_set_index = '0;
   logic [1:0]             req_way_index = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_hit;
   logic [1:0]             rsp_way;
   logic                   rsp_writeback;
   logic [31:0]            rsp_writeback_address;
   logic                   rsp_fill;
   logic [31:0]            rsp_fill_address;
   logic                   rsp_mem_write;
   logic                   rsp_all_locked;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  cycle_count = 0;
   cache_tag_scoreboard board = new();

   set_assoc_cache_tag_policy_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_address           (req_address),
      .req_phys_address      (req_phys_address),
      .req_set_index         (req_set_index),
      .req_way_index         (req_way_index),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_hit               (rsp_hit),
      .rsp_way               (rsp_way),
      .rsp_writeback         (rsp_writeback),
      .rsp_writeback_address (rsp_writeback_address),
      .rsp_fill              (rsp_fill),
      .rsp_fill_address      (rsp_fill_address),
      .rsp_mem_write         (rsp_mem_write),
      .rsp_all_locked        (rsp_all_locked),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // sample handshakes with pre-edge values
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && csr_valid && csr_ready) board.write_register(csr_index, csr_data);
      if (!reset && req_valid && req_ready)
         board.note_request(req_type, req_address, req_phys_address,
                            req_set_index, req_way_index);
      if (!reset && rsp_valid && rsp_ready)
         board.check_response({rsp_hit, rsp_way, rsp_writeback, rsp_writeback_address,
                               rsp_fill, rsp_fill_address, rsp_mem_write,
                               rsp_all_locked});
   end

   // leaves req_valid high; the caller drops it when the stream pauses
   task automatic send_request(input logic [3:0] op, input logic [31:0] addr,
                               input logic [31:0] phys, input logic [5:0] set_sel,
                               input logic [1:0] way_sel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= op;
      req_address      <= addr;
      req_phys_address <= phys;
      req_set_index    <= set_sel;
      req_way_index    <= way_sel;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // step past the last accepting edge so its word is already noted
   task automatic drain();
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int          phase, n, pick;
      logic [3:0]  op;
      logic [31:0] addr, tag_val, set_val;
      logic [5:0]  set_sel;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed pass at reset settings: write-back, nothing locked
      send_request(REQ_READ, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0, 2'd0);
      send_request(REQ_READ, 32'h0000_0000, 32'h0000_0000, 6'd0, 2'd0);
      send_request(REQ_WRITE, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0, 2'd0);
      send_request(REQ_WRITE, 32'hFFFF_FFFF, 32'h1234_5678, 6'd0, 2'd0);
      send_request(REQ_CLEAN_VA, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0, 2'd0);
      send_request(REQ_WRITE, 32'hFFFF_FFE0, 32'h0000_0000, 6'd0, 2'd0);
      // invalid but still dirty, then cleaned by set/way
      send_request(REQ_INVAL_VA, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0, 2'd0);
      send_request(REQ_CLEAN_SW, 32'h0000_0000, 32'h0000_0000, 6'd63, 2'd0);
      send_request(REQ_WRITE, 32'hFFFF_FFFF, 32'h8000_001F, 6'd0, 2'd0);
      send_request(REQ_CLEAN_INVAL_VA, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0, 2'd0);
      send_request(REQ_WRITE, 32'h0000_0000, 32'h0000_0000, 6'd0, 2'd0);
      send_request(REQ_CLEAN_INVAL_SW, 32'h0000_0000, 32'h0000_0000, 6'd0, 2'd0);
      // fill all four ways of set 0, then evict
      send_request(REQ_READ, 32'h0000_0800, 32'h0000_1000, 6'd0, 2'd0);
      send_request(REQ_READ, 32'h0000_1000, 32'h0000_2000, 6'd0, 2'd0);
      send_request(REQ_READ, 32'h0000_1800, 32'h0000_3000, 6'd0, 2'd0);
      send_request(REQ_READ, 32'h0000_2000, 32'h0000_4000, 6'd0, 2'd0);
      send_request(REQ_READ, 32'h0000_2800, 32'h0000_5000, 6'd0, 2'd0);
      send_request(REQ_WRITE, 32'h0000_3000, 32'h0000_6000, 6'd0, 2'd0);
      send_request(REQ_READ, 32'h0000_3800, 32'h0000_7000, 6'd0, 2'd0);
      send_request(REQ_INVAL_SW, 32'h0000_0000, 32'h0000_0000, 6'd0, 2'd1);
      send_request(REQ_INVAL_ALL, 32'h0000_0000, 32'h0000_0000, 6'd0, 2'd0);
      send_request(4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 2'd3);
      send_request(4'h9, 32'h0000_0000, 32'h0000_0000, 6'd0, 2'd0);
      send_request(REQ_INVAL_VA, 32'h0000_0000, 32'h0000_0000, 6'd0, 2'd0);
      send_request(REQ_CLEAN_SW, 32'h0000_0000, 32'h0000_0000, 6'd63, 2'd3);

      for (phase = 0; phase < PHASES; phase++) begin
         req_valid <= 1'b0;
         drain();
         // let the back end settle before touching the registers
         repeat (4) @(posedge clock);
         write_register(CSR_WRITE_BACK_MODE, CSR_DATA_W'(PHASE_MODE[phase]));
         write_register(CSR_LOCK_BASE, PHASE_LOCK[phase]);
         csr_valid <= 1'b0;
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 35)      op = REQ_READ;
            else if (pick < 65) op = REQ_WRITE;
            else if (pick < 70) op = REQ_INVAL_VA;
            else if (pick < 76) op = REQ_CLEAN_VA;
            else if (pick < 81) op = REQ_CLEAN_INVAL_VA;
            else if (pick < 82) op = REQ_INVAL_ALL;
            else if (pick < 87) op = REQ_INVAL_SW;
            else if (pick < 92) op = REQ_CLEAN_SW;
            else if (pick < 97) op = REQ_CLEAN_INVAL_SW;
            else                op = 4'($urandom_range(15, 9));
            // mostly a small pool of tags and sets so lines collide and hit
            if ($urandom_range(9) == 0) begin
               addr = $urandom();
            end else begin
               tag_val = ($urandom_range(9) == 0) ? $urandom() : TAG_POOL[$urandom_range(5)];
               set_val = ($urandom_range(9) == 0) ? 32'($urandom_range(SETS - 1))
                                                  : SET_POOL[$urandom_range(3)];
               addr = (tag_val * SETS + set_val) * LINE_SIZE + $urandom_range(LINE_SIZE - 1);
            end
            set_sel = ($urandom_range(4) == 0) ? 6'($urandom_range(63))
                                               : 6'(SET_POOL[$urandom_range(3)]);
            send_request(op, addr, $urandom(), set_sel, 2'($urandom_range(3)));
         end
      end

      req_valid <= 1'b0;
      drain();
      repeat (8) @(posedge clock);
      if (board.error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
